FILE: design/windowed_peak_trigger_top_macros.svh
// assertion macros shared by the windowed peak trigger design
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef WINDOWED_PEAK_TRIGGER_TOP_MACROS_SVH
`define WINDOWED_PEAK_TRIGGER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define WPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define WPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wpt_pkg.sv
// shared constants and register codes for the windowed peak trigger
// no dependencies
package wpt_pkg;

  localparam int NumChannelsDef = 4;
  localparam int SampleBitsDef  = 10;

  localparam int ChBits      = 2;
  localparam int ThrBits     = 10;
  localparam int PeakOutBits = 10;
  localparam int CountBits   = 17;
  localparam int MaxScanBits = 16;
  localparam int TimeBits    = 32;
  localparam int NumThr      = 4;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam logic [MaxScanBits-1:0] MaxScanReset = MaxScanBits'(10);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MAX_SCAN = 3'd0,
    CFG_THR_CH0  = 3'd1,
    CFG_THR_CH1  = 3'd2,
    CFG_THR_CH2  = 3'd3,
    CFG_THR_CH3  = 3'd4
  } cfg_idx_e;

endpackage

FILE: design/wpt_if.sv
// valid/ready channel interfaces: sample input, hit output, register writes
// depends on wpt_pkg
interface wpt_smp_if #(
  parameter int SAMPLE_BITS = wpt_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic [wpt_pkg::ChBits-1:0]    channel_index;
  logic [SAMPLE_BITS-1:0]        sample;
  logic [wpt_pkg::TimeBits-1:0]  now_ms;

  modport source (output valid, channel_index, sample, now_ms, input ready);
  modport sink   (input valid, channel_index, sample, now_ms, output ready);
endinterface

interface wpt_hit_if;
  logic                             valid;
  logic                             ready;
  logic [wpt_pkg::ChBits-1:0]       hit_channel;
  logic [wpt_pkg::PeakOutBits-1:0]  hit_peak;

  modport source (output valid, hit_channel, hit_peak, input ready);
  modport sink   (input valid, hit_channel, hit_peak, output ready);
endinterface

interface wpt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wpt_pkg::CfgIdxBits-1:0]   index;
  logic [wpt_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/windowed_peak_trigger_top.sv
// windowed peak trigger: per-channel peak windows held in one small state memory
// depends on wpt_pkg, wpt_if.sv and windowed_peak_trigger_top_macros.svh
//
// takes one sample word per cycle, back to back, on any mix of channels. a word
// goes through two stages: at acceptance the channel entry (peak, count, next
// time) is read from the state memory, and as the word leaves the update stage
// the entry is updated and written back. a word for the channel that is being
// written in the same cycle gets the new entry by forwarding, so repeated words
// on one channel need no gap. a hit word is loaded into the output register as
// the word that closed the window leaves the update stage. input ready drops
// only while a hit waits in the stage and the output register is still held by
// an earlier hit. the entries need no clearing pass: a valid bit per channel
// makes an entry read as zero until it is first written. register writes are
// taken in any cycle, ready stays high.
`include "windowed_peak_trigger_top_macros.svh"

module windowed_peak_trigger_top #(
  parameter int NUM_CHANNELS = wpt_pkg::NumChannelsDef,
  parameter int SAMPLE_BITS  = wpt_pkg::SampleBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpt_smp_if.sink   in_i,
  wpt_hit_if.source hit_o,
  wpt_cfg_if.sink   cfg_i
);
  import wpt_pkg::*;

  localparam int AddrBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CmpBits  = (SAMPLE_BITS > ThrBits) ? SAMPLE_BITS : ThrBits;

  // one memory entry per channel
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [CountBits-1:0]   count;
    logic [TimeBits-1:0]    next_time;
  } entry_t;

  // configuration registers
  logic [MaxScanBits-1:0] max_scan_q;
  logic [ThrBits-1:0]     thr_q [NumThr];

  // state memory, valid bits and registered read word
  entry_t                 mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  entry_t                 rd_q;

  // update stage
  logic                   s1_valid_q;
  logic [ChBits-1:0]      s1_ch_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;
  logic [TimeBits-1:0]    s1_now_q;

  // output register
  logic                   out_vld_q;
  logic [ChBits-1:0]      out_ch_q;
  logic [PeakOutBits-1:0] out_peak_q;

  logic                   in_fire;
  logic                   in_range;
  logic [AddrBits-1:0]    in_addr;
  logic [AddrBits-1:0]    wr_addr;
  logic                   s1_close;
  logic                   s1_take;
  logic                   s1_hit;
  logic                   s1_adv;
  logic                   wr_en;
  entry_t                 wr_data;
  logic [CmpBits-1:0]     pk_ext;
  logic [CmpBits-1:0]     thr_ext;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_scan_q <= MaxScanReset;
      for (int i = 0; i < NumThr; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MAX_SCAN: max_scan_q <= cfg_i.data;
        CFG_THR_CH0:  thr_q[0]   <= cfg_i.data[ThrBits-1:0];
        CFG_THR_CH1:  thr_q[1]   <= cfg_i.data[ThrBits-1:0];
        CFG_THR_CH2:  thr_q[2]   <= cfg_i.data[ThrBits-1:0];
        CFG_THR_CH3:  thr_q[3]   <= cfg_i.data[ThrBits-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  assign in_fire  = in_i.valid && in_i.ready;
  // channels past the configured count are accepted and dropped
  assign in_range = ({1'b0, in_i.channel_index} < (ChBits + 1)'(NUM_CHANNELS));
  assign in_addr  = AddrBits'(in_i.channel_index);
  assign wr_addr  = AddrBits'(s1_ch_q);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // ---------------------------------------------------------------- update stage
  assign s1_close = (rd_q.count > {1'b0, max_scan_q});
  assign s1_take  = !s1_close && (s1_now_q >= rd_q.next_time);
  assign pk_ext   = CmpBits'(rd_q.peak);
  assign thr_ext  = CmpBits'(thr_q[s1_ch_q]);
  assign s1_hit   = s1_close && (pk_ext > thr_ext);
  // a hit may leave only when the output register is free or being emptied
  assign s1_adv   = !s1_hit || !out_vld_q || hit_o.ready;
  assign wr_en    = s1_valid_q && s1_adv && (s1_close || s1_take);

  always_comb begin
    wr_data = rd_q;
    if (s1_close) begin
      wr_data = '0;
    end else if (s1_take) begin
      if (s1_smp_q > rd_q.peak) begin
        wr_data.peak = s1_smp_q;
      end
      wr_data.count     = rd_q.count + CountBits'(1);
      wr_data.next_time = s1_now_q + TimeBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= in_range;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q  <= in_i.channel_index;
      s1_smp_q <= in_i.sample;
      s1_now_q <= in_i.now_ms;
    end
  end

  // ---------------------------------------------------------------- state memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // read-modify-write with write-to-read forwarding on the same channel
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      if (wr_en && (wr_addr == in_addr)) begin
        rd_q <= wr_data;
      end else if (vld_q[in_addr]) begin
        rd_q <= mem_q[in_addr];
      end else begin
        rd_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_valid_q && s1_adv && s1_hit) begin
      out_vld_q <= 1'b1;
    end else if (hit_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv && s1_hit) begin
      out_ch_q   <= s1_ch_q;
      out_peak_q <= PeakOutBits'(rd_q.peak);
    end
  end

  assign hit_o.valid       = out_vld_q;
  assign hit_o.hit_channel = out_ch_q;
  assign hit_o.hit_peak    = out_peak_q;

  // ---------------------------------------------------------------- checks
  `WPT_ASSERT_NOW(a_stall_needs_full_out, s1_valid_q && !s1_adv,
                  out_vld_q && !hit_o.ready, "stage stalled without a pending hit")
  `WPT_ASSERT_NEXT(a_stall_holds_stage, s1_valid_q && !s1_adv,
                   s1_valid_q && $stable(s1_ch_q) && $stable(rd_q), "stalled stage lost its word")
  `WPT_ASSERT_NOW(a_no_hit_overwrite, s1_valid_q && s1_adv && s1_hit,
                  !out_vld_q || hit_o.ready, "hit overwrote a pending result")
  `WPT_ASSERT_NEXT(a_close_clears_entry, wr_en && s1_close,
                   vld_q[$past(wr_addr)] && (mem_q[$past(wr_addr)] == '0),
                   "closed window left state behind")

endmodule
